// ===== sv/bpsd_pkg.sv =====
`default_nettype none

package bpsd_pkg;

    localparam int BTN_W   = 2;
    localparam int MASK_W  = 3;
    localparam int LEVEL_W = 4;
    localparam int TIME_W  = 32;
    localparam int DEB_W   = 16;
    localparam int LINE_W  = 3;
    localparam int LED_W   = 4;
    localparam int EVENT_W = 2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

    typedef enum logic [1:0] {
        OP_SCAN       = 2'd0,
        OP_SET_COLOR  = 2'd1,
        OP_READ_CLEAR = 2'd2,
        OP_FORCE      = 2'd3
    } op_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_UP   = 2'd2
    } event_t;

    // One operation as it leaves the input register.
    typedef struct packed {
        logic                  fire;
        op_t                   op;
        logic [BTN_W-1:0]      button;
        logic [MASK_W-1:0]     color_mask;
        logic [LEVEL_W-1:0]    switch_levels;
        logic [TIME_W-1:0]     time_ms;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/bpsd_scan.sv =====
`default_nettype none

module bpsd_scan
    import bpsd_pkg::*;
#(
    parameter int BUTTONS = 4,
    parameter int COLORS  = 3
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output logic [LINE_W-1:0]      color_lines_next,
    output logic [LED_W-1:0]       led_lines_next
);

    localparam int CW = (COLORS > 1) ? $clog2(COLORS) : 1;
    localparam logic [CW-1:0] LAST_COLOR = CW'(COLORS - 1);

    logic [CW-1:0]     current_color_reg;
    logic [CW-1:0]     current_color_next;
    logic [MASK_W-1:0] led_color_reg [BUTTONS];
    logic [LINE_W-1:0] color_lines_reg;
    logic [LED_W-1:0]  led_lines_reg;
    logic [MASK_W-1:0] color_hit;
    logic [LED_W-1:0]  led_scan;
    logic              scan_go;

    assign scan_go = cmd.fire && (cmd.op == OP_SCAN);

    // A colour index beyond the stored mask bits lights nothing and drives no line.
    always_comb begin
        for (int k = 0; k < MASK_W; k++) begin
            color_hit[k] = (32'(current_color_reg) == k);
        end
    end

    for (genvar i = 0; i < LED_W; i++) begin : g_led
        if (i < BUTTONS) begin : g_used
            assign led_scan[i] = |(led_color_reg[i] & color_hit);
        end else begin : g_unused
            assign led_scan[i] = 1'b0;
        end
    end

    always_comb begin
        if (current_color_reg == LAST_COLOR) begin
            current_color_next = '0;
        end else begin
            current_color_next = current_color_reg + CW'(1);
        end
        color_lines_next = scan_go ? ~color_hit : color_lines_reg;
        led_lines_next   = scan_go ? led_scan : led_lines_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_color_reg <= '0;
            color_lines_reg   <= '1;
            led_lines_reg     <= '0;
        end else if (scan_go) begin
            current_color_reg <= current_color_next;
            color_lines_reg   <= color_lines_next;
            led_lines_reg     <= led_lines_next;
        end
    end

    for (genvar i = 0; i < BUTTONS; i++) begin : g_mask
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                led_color_reg[i] <= '0;
            end else if (cmd.fire && cmd.op == OP_SET_COLOR
                         && 32'(cmd.button) == i) begin
                led_color_reg[i] <= cmd.color_mask;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bpsd_debounce.sv =====
`default_nettype none

module bpsd_debounce
    import bpsd_pkg::*;
#(
    parameter int BUTTONS = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    input  wire logic [DEB_W-1:0]  debounce_ms,
    output event_t                 event_code
);

    logic              last_pressed_reg [BUTTONS];
    logic [TIME_W-1:0] last_time_reg    [BUTTONS];
    event_t            pending_reg      [BUTTONS];
    logic [BUTTONS-1:0] btn_sel;

    for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
        logic              pressed;
        logic [TIME_W-1:0] elapsed;
        logic              accept_change;

        // Buttons with no level bit in the field read as pressed.
        if (i < LEVEL_W) begin : g_pin
            assign pressed = ~cmd.switch_levels[i];
        end else begin : g_nopin
            assign pressed = 1'b1;
        end

        assign btn_sel[i] = (32'(cmd.button) == i);
        assign elapsed    = cmd.time_ms - last_time_reg[i];
        assign accept_change = cmd.fire && (cmd.op == OP_SCAN)
                               && (pressed != last_pressed_reg[i])
                               && (elapsed > TIME_W'(debounce_ms));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                last_pressed_reg[i] <= 1'b0;
                last_time_reg[i]    <= '0;
                pending_reg[i]      <= EV_NONE;
            end else begin
                if (accept_change) begin
                    last_pressed_reg[i] <= pressed;
                    last_time_reg[i]    <= cmd.time_ms;
                    pending_reg[i]      <= pressed ? EV_DOWN : EV_UP;
                end else if (cmd.fire && btn_sel[i]) begin
                    if (cmd.op == OP_READ_CLEAR) begin
                        pending_reg[i] <= EV_NONE;
                    end else if (cmd.op == OP_FORCE) begin
                        pending_reg[i] <= pressed ? EV_DOWN : EV_UP;
                    end
                end
            end
        end
    end

    always_comb begin
        logic [EVENT_W-1:0] ev;
        ev = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            if (btn_sel[i]) begin
                ev = ev | pending_reg[i];
            end
        end
        event_code = (cmd.op == OP_READ_CLEAR) ? event_t'(ev) : EV_NONE;
    end

endmodule

`default_nettype wire

// ===== sv/button_pad_scan_debounce_unit.sv =====
// m_tvalid rises once an item has passed the input register and the result register.
// Throughput: one item per cycle while m_tready drains the result; the input
// register and the result register form a two-stage pipeline, so a new item
// can wait in the input register while a result waits for m_tready.
// Reset (aresetn low, synchronous): color lines off, LEDs off, all buttons
// released with no pending events, debounce time back to 20 ms.
`default_nettype none

module button_pad_scan_debounce_unit
    import bpsd_pkg::*;
#(
    parameter int BUTTONS = 4,
    parameter int COLORS  = 3
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [DEB_W-1:0]  cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // button[1:0], color_mask[4:2], switch_levels[8:5], time_ms[40:9]
    input  wire logic [47:0]       s_tdata,
    // operation[1:0]
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // color_lines[2:0], led_lines[6:3], event_code[8:7]
    output logic [15:0]            m_tdata
);

    logic [DEB_W-1:0]  debounce_reg;
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    cmd_t              cmd;
    logic              advance;
    logic              out_valid_reg;
    logic [LINE_W-1:0] out_lines_reg;
    logic [LED_W-1:0]  out_leds_reg;
    event_t            out_event_reg;
    logic [LINE_W-1:0] color_lines_next;
    logic [LED_W-1:0]  led_lines_next;
    event_t            event_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_wr_en) begin
            debounce_reg <= cfg_wr_data;
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg.fire          <= 1'b1;
            in_cmd_reg.op            <= op_t'(s_tuser);
            in_cmd_reg.button        <= s_tdata[1:0];
            in_cmd_reg.color_mask    <= s_tdata[4:2];
            in_cmd_reg.switch_levels <= s_tdata[8:5];
            in_cmd_reg.time_ms       <= s_tdata[40:9];
        end
    end

    always_comb begin
        cmd      = in_cmd_reg;
        cmd.fire = advance;
    end

    bpsd_scan #(
        .BUTTONS (BUTTONS),
        .COLORS  (COLORS)
    ) u_scan (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .color_lines_next (color_lines_next),
        .led_lines_next   (led_lines_next)
    );

    bpsd_debounce #(
        .BUTTONS (BUTTONS)
    ) u_debounce (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .debounce_ms (debounce_reg),
        .event_code  (event_code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_lines_reg <= color_lines_next;
            out_leds_reg  <= led_lines_next;
            out_event_reg <= event_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_event_reg, out_leds_reg, out_lines_reg};

    // A stalled result is never overwritten by the next item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && out_valid_reg && !m_tready))
        else $error("result register overwritten while stalled");

    // At most one color common line is driven low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(~m_tdata[2:0]))
        else $error("more than one color line active");

    // Only a read-clear reports an event, and never the unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_cmd_reg.op != OP_READ_CLEAR |=> m_tdata[8:7] == EV_NONE)
        else $error("event reported outside a read-clear");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:7] != 2'd3)
        else $error("invalid event code");

endmodule

`default_nettype wire
